// File: design/atmb_pkg.sv
// Shared types, constants and elaboration-time helpers for the
// scale-rotate-translate matrix builder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atmb_pkg;

   localparam int ELEM_W         = 32;
   localparam int ANGLE_FIELD_W  = 12;
   localparam int AXIS_W         = 2;
   localparam int INDEX_W        = 4;
   localparam int DEF_ANGLE_BITS = 12;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int MAX_FRAC_BITS  = 24;
   localparam int TRIG_W         = MAX_FRAC_BITS + 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(15);
   localparam logic [1:0]         TRANS_ROW  = 2'd3;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam int ROT_CODE_W = 3;
   localparam logic [ROT_CODE_W-1:0] ROT_ZERO    = 3'd0;
   localparam logic [ROT_CODE_W-1:0] ROT_ONE     = 3'd1;
   localparam logic [ROT_CODE_W-1:0] ROT_COS     = 3'd2;
   localparam logic [ROT_CODE_W-1:0] ROT_SIN     = 3'd3;
   localparam logic [ROT_CODE_W-1:0] ROT_NEG_SIN = 3'd4;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   typedef struct packed {
      logic signed [ELEM_W-1:0] offset_x;
      logic signed [ELEM_W-1:0] offset_y;
      logic signed [ELEM_W-1:0] offset_z;
      logic signed [ELEM_W-1:0] scale_x;
      logic signed [ELEM_W-1:0] scale_y;
      logic signed [ELEM_W-1:0] scale_z;
      logic [ANGLE_FIELD_W-1:0] turn_angle;
      logic [AXIS_W-1:0]        turn_axis;
   } atmb_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]       element_index;
      logic signed [ELEM_W-1:0] element_value;
      logic                     last_element;
   } atmb_rsp_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] offset_x;
      logic signed [ELEM_W-1:0] offset_y;
      logic signed [ELEM_W-1:0] offset_z;
      logic signed [ELEM_W-1:0] scale_x;
      logic signed [ELEM_W-1:0] scale_y;
      logic signed [ELEM_W-1:0] scale_z;
      logic [AXIS_W-1:0]        turn_axis;
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } atmb_cmd_type;

   function automatic logic [ROT_CODE_W-1:0] rot_code(input logic [AXIS_W-1:0] axis,
                                                      input logic [1:0] row,
                                                      input logic [1:0] col);
      logic [ROT_CODE_W-1:0] code;
      code = (row == col) ? ROT_ONE : ROT_ZERO;
      case (axis)
         AXIS_X: begin
            if ((row == 2'd1 && col == 2'd1) || (row == 2'd2 && col == 2'd2)) code = ROT_COS;
            if (row == 2'd1 && col == 2'd2) code = ROT_SIN;
            if (row == 2'd2 && col == 2'd1) code = ROT_NEG_SIN;
         end
         AXIS_Y: begin
            if ((row == 2'd0 && col == 2'd0) || (row == 2'd2 && col == 2'd2)) code = ROT_COS;
            if (row == 2'd2 && col == 2'd0) code = ROT_SIN;
            if (row == 2'd0 && col == 2'd2) code = ROT_NEG_SIN;
         end
         AXIS_Z: begin
            if ((row == 2'd0 && col == 2'd0) || (row == 2'd1 && col == 2'd1)) code = ROT_COS;
            if (row == 2'd0 && col == 2'd1) code = ROT_SIN;
            if (row == 2'd1 && col == 2'd0) code = ROT_NEG_SIN;
         end
         default: begin
            code = (row == col) ? ROT_ONE : ROT_ZERO;
         end
      endcase
      return code;
   endfunction

   // Upper bits of a Q62 by Q62 product, kept as Q62.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Taylor term divisor (n+1)(n+2) for odd n.
   function automatic logic [63:0] div_step(input logic [63:0] t, input int n);
      logic [63:0] q;
      case (n)
         1:       q = t / 64'd6;
         3:       q = t / 64'd20;
         5:       q = t / 64'd42;
         7:       q = t / 64'd72;
         9:       q = t / 64'd110;
         11:      q = t / 64'd156;
         13:      q = t / 64'd210;
         15:      q = t / 64'd272;
         17:      q = t / 64'd342;
         19:      q = t / 64'd420;
         21:      q = t / 64'd506;
         23:      q = t / 64'd600;
         25:      q = t / 64'd702;
         27:      q = t / 64'd812;
         29:      q = t / 64'd930;
         31:      q = t / 64'd1056;
         33:      q = t / 64'd1190;
         35:      q = t / 64'd1332;
         37:      q = t / 64'd1482;
         39:      q = t / 64'd1640;
         41:      q = t / 64'd1806;
         43:      q = t / 64'd1980;
         45:      q = t / 64'd2162;
         47:      q = t / 64'd2352;
         49:      q = t / 64'd2550;
         51:      q = t / 64'd2756;
         53:      q = t / 64'd2970;
         55:      q = t / 64'd3192;
         57:      q = t / 64'd3422;
         default: q = t / 64'd3660;
      endcase
      return q;
   endfunction

   // Quarter-wave sine entry k of 2^qbits, rounded to frac fraction bits.
   function automatic logic [31:0] sine_value(input int k, input int qbits, input int frac);
      logic [63:0]  fr;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  r;
      logic [127:0] p;
      logic         minus;
      int           n;
      int           it;
      fr = 64'(k) << (64 - qbits);
      p = {64'd0, fr} * {64'd0, HALF_PI_Q62};
      x = p[127:64];
      x2 = mul_q62(x, x);
      term = x;
      sum = x;
      n = 1;
      minus = 1'b1;
      for (it = 0; it < 30; it++) begin
         if (term != 64'd0) begin
            term = div_step(mul_q62(term, x2), n);
            n = n + 2;
            sum = minus ? (sum - term) : (sum + term);
            minus = !minus;
         end
      end
      r = (sum + (64'd1 << (61 - frac))) >> (62 - frac);
      if (r > (64'd1 << frac)) r = 64'd1 << frac;
      return r[31:0];
   endfunction

endpackage

`default_nettype wire

// File: design/atmb_front.sv
// Front end of the matrix builder: accepts request items, looks up sine
// and cosine in the quarter-wave ROM and hands a command to the queue. Uses atmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atmb_front #(
   parameter int ANGLE_BITS = atmb_pkg::DEF_ANGLE_BITS,
   parameter int FRAC_BITS  = atmb_pkg::DEF_FRAC_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  atmb_pkg::atmb_req_type req_item,
   output logic                   cmd_valid,
   input  wire                    cmd_stall,
   output atmb_pkg::atmb_cmd_type cmd_item
);

   localparam int QBITS       = ANGLE_BITS - 2;
   localparam int ROM_ENTRIES = (2 ** QBITS) + 1;
   localparam int ROM_AW      = QBITS + 1;
   localparam int ROM_W       = FRAC_BITS + 1;
   localparam int TRIG_W      = atmb_pkg::TRIG_W;
   localparam logic [ROM_AW-1:0] QUARTER = ROM_AW'(2 ** QBITS);

   typedef logic [ROM_W-1:0] sine_rom_type [ROM_ENTRIES];

   function automatic sine_rom_type build_rom();
      sine_rom_type rom;
      int           k;
      for (k = 0; k < ROM_ENTRIES; k++) begin
         if (k == ROM_ENTRIES - 1) begin
            rom[k] = ROM_W'(2 ** FRAC_BITS);
         end else begin
            rom[k] = ROM_W'(atmb_pkg::sine_value(k, QBITS, FRAC_BITS));
         end
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_rom();

   logic [ANGLE_BITS-1:0]    angle;
   logic [QBITS-1:0]         rem;
   logic [ROM_AW-1:0]        addr_a;
   logic [ROM_AW-1:0]        addr_b;
   logic                     load;
   logic                     valid_ff;
   logic                     valid_in;
   atmb_pkg::atmb_req_type   item_ff;
   logic [1:0]               quad_ff;
   logic [ROM_W-1:0]         rom_a_ff;
   logic [ROM_W-1:0]         rom_b_ff;
   logic [ROM_W-1:0]         s_mag;
   logic [ROM_W-1:0]         c_mag;
   logic signed [TRIG_W-1:0] s_ext;
   logic signed [TRIG_W-1:0] c_ext;

   assign angle  = ANGLE_BITS'(req_item.turn_angle);
   assign rem    = angle[QBITS-1:0];
   assign addr_a = {1'b0, rem};
   assign addr_b = QUARTER - {1'b0, rem};

   assign load      = !valid_ff || !cmd_stall;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff  <= req_item;
         quad_ff  <= angle[ANGLE_BITS-1 -: 2];
         rom_a_ff <= SINE_ROM[addr_a];
         rom_b_ff <= SINE_ROM[addr_b];
      end
   end

   always_comb begin
      s_mag = quad_ff[0] ? rom_b_ff : rom_a_ff;
      c_mag = quad_ff[0] ? rom_a_ff : rom_b_ff;
      s_ext = {{(TRIG_W - ROM_W){1'b0}}, s_mag};
      c_ext = {{(TRIG_W - ROM_W){1'b0}}, c_mag};
      cmd_item.offset_x  = item_ff.offset_x;
      cmd_item.offset_y  = item_ff.offset_y;
      cmd_item.offset_z  = item_ff.offset_z;
      cmd_item.scale_x   = item_ff.scale_x;
      cmd_item.scale_y   = item_ff.scale_y;
      cmd_item.scale_z   = item_ff.scale_z;
      cmd_item.turn_axis = item_ff.turn_axis;
      cmd_item.sin_val   = quad_ff[1] ? -s_ext : s_ext;
      cmd_item.cos_val   = (quad_ff[0] ^ quad_ff[1]) ? -c_ext : c_ext;
   end

   assign cmd_valid = valid_ff;

endmodule

`default_nettype wire

// File: design/atmb_queue.sv
// Short command queue between the front end and the element sequencer.
// Uses atmb_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module atmb_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   output logic                   push_stall,
   input  atmb_pkg::atmb_cmd_type push_item,
   output logic                   head_valid,
   input  wire                    head_pop,
   output atmb_pkg::atmb_cmd_type head_item
);

   localparam int DEPTH = atmb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   atmb_pkg::atmb_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   push;
   logic                   pop;

   assign push_stall = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/atmb_back.sv
// Back end of the matrix builder: walks the sixteen elements of the head
// command through a multiply stage and a rounding stage. Uses atmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atmb_back #(
   parameter int FRAC_BITS = atmb_pkg::DEF_FRAC_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    head_valid,
   output logic                   head_pop,
   input  atmb_pkg::atmb_cmd_type head_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output atmb_pkg::atmb_rsp_type rsp_item
);

   localparam int ELEM_W  = atmb_pkg::ELEM_W;
   localparam int TRIG_W  = atmb_pkg::TRIG_W;
   localparam int INDEX_W = atmb_pkg::INDEX_W;
   localparam int PROD_W  = ELEM_W + TRIG_W;
   localparam int HIGH_W  = PROD_W - ELEM_W + 1;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(2 ** FRAC_BITS);
   localparam logic signed [ELEM_W-1:0] ELEM_ONE = ELEM_W'(2 ** FRAC_BITS);
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};

   logic                           advance;
   logic                           issue;
   logic [INDEX_W-1:0]             idx_ff;
   logic [INDEX_W-1:0]             idx_in;
   logic [1:0]                     row;
   logic [1:0]                     col;
   logic [atmb_pkg::ROT_CODE_W-1:0] code;
   logic signed [ELEM_W-1:0]       op_a;
   logic signed [TRIG_W-1:0]       op_b;
   logic signed [PROD_W-1:0]       prod_in;
   logic                           prod_valid_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic [INDEX_W-1:0]             prod_idx_ff;
   logic signed [PROD_W-1:0]       rounded;
   logic [HIGH_W-1:0]              high_bits;
   logic signed [ELEM_W-1:0]       value_in;
   logic                           rsp_valid_ff;
   atmb_pkg::atmb_rsp_type         rsp_item_ff;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign issue    = advance && head_valid;
   assign head_pop = issue && (idx_ff == atmb_pkg::LAST_INDEX);
   assign idx_in   = issue ? idx_ff + 1'b1 : idx_ff;

   assign row = idx_ff[3:2];
   assign col = idx_ff[1:0];

   always_comb begin
      code = atmb_pkg::rot_code(head_item.turn_axis, row, col);
      op_b = TRIG_ONE;
      if (row == atmb_pkg::TRANS_ROW) begin
         case (col)
            2'd0:    op_a = head_item.offset_x;
            2'd1:    op_a = head_item.offset_y;
            2'd2:    op_a = head_item.offset_z;
            default: op_a = ELEM_ONE;
         endcase
      end else begin
         case (row)
            2'd0:    op_a = head_item.scale_x;
            2'd1:    op_a = head_item.scale_y;
            default: op_a = head_item.scale_z;
         endcase
         case (code)
            atmb_pkg::ROT_ONE:     op_b = TRIG_ONE;
            atmb_pkg::ROT_COS:     op_b = head_item.cos_val;
            atmb_pkg::ROT_SIN:     op_b = head_item.sin_val;
            atmb_pkg::ROT_NEG_SIN: op_b = -head_item.sin_val;
            default:               op_b = '0;
         endcase
      end
      prod_in = op_a * op_b;
   end

   always_comb begin
      rounded   = (prod_ff + HALF_LSB) >>> FRAC_BITS;
      high_bits = rounded[PROD_W-1:ELEM_W-1];
      if (high_bits == '0 || high_bits == '1) begin
         value_in = rounded[ELEM_W-1:0];
      end else if (rounded[PROD_W-1]) begin
         value_in = ELEM_MIN;
      end else begin
         value_in = ELEM_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (advance) begin
            prod_valid_ff <= issue;
            rsp_valid_ff  <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff                   <= prod_in;
         prod_idx_ff               <= idx_ff;
         rsp_item_ff.element_index <= prod_idx_ff;
         rsp_item_ff.element_value <= value_in;
         rsp_item_ff.last_element  <= (prod_idx_ff == atmb_pkg::LAST_INDEX);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   midway_needs_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> head_valid)
      else $error("Element counter is mid-matrix with no command at the queue head.");

   stall_holds_product: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(prod_valid_ff) && $stable(prod_idx_ff)))
      else $error("Product stage moved while the result register was stalled.");

   pop_after_last: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (prod_valid_ff && prod_idx_ff == atmb_pkg::LAST_INDEX))
      else $error("Command left the queue without its last element entering the multiplier.");

endmodule

`default_nettype wire

// File: design/affine_transform_matrix_build.sv
// Scale-rotate-translate matrix builder, top level.
// Each request item carries a translation, three row scales, an angle and
// a rotation axis; the block returns the 4x4 column-major matrix as sixteen
// result items with indexes 0 to 15, the last marked by last_element.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low.
// With no stalls, the first element of a matrix reaches the result port once
// its request has passed the ROM read register, the queue and the multiply
// register, then been rounded and saturated into the result register.
// The element sequencer drives one element a cycle while the result is not
// stalled, sixteen per request item, through a single 32 by 26 multiplier.
// A new request is taken while the previous matrix is still being sent;
// the command queue holds the request being expanded and one more, and the
// front end register holds a third.
// Reset clears the pipeline valid bits, queue pointers and element counter;
// the sine ROM is constant and needs no fill.
// A stalled result holds; the multiplier stage and sequencer hold behind it
// and the queue and front end stall once full.
// Depends on atmb_pkg, atmb_front, atmb_queue and atmb_back.
`timescale 1ns / 1ps
`default_nettype none

module affine_transform_matrix_build #(
   parameter int ANGLE_BITS = atmb_pkg::DEF_ANGLE_BITS,
   parameter int FRAC_BITS  = atmb_pkg::DEF_FRAC_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  atmb_pkg::atmb_req_type req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output atmb_pkg::atmb_rsp_type rsp_item
);

   logic                   cmd_valid;
   logic                   cmd_stall;
   atmb_pkg::atmb_cmd_type cmd_item;
   logic                   head_valid;
   logic                   head_pop;
   atmb_pkg::atmb_cmd_type head_item;

   atmb_front #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_stall (cmd_stall),
      .cmd_item  (cmd_item)
   );

   atmb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_stall (cmd_stall),
      .push_item  (cmd_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_item  (head_item)
   );

   atmb_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_item  (head_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for affine_transform_matrix_build: a scoreboard
// builds each expected 4x4 matrix and checks the sixteen elements in order.
// Depends on atmb_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_top;

   localparam int ANGLE_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int QUARTER      = 1 << (ANGLE_BITS - 2);
   localparam longint UNITY    = longint'(1) << FRAC_BITS;
   localparam bit [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;
   localparam int RANDOM_ITEMS = 156;
   localparam int IDLE_LIMIT   = 1000;

   class matrix_scoreboard;
      longint                 sine_lut[QUARTER + 1];
      atmb_pkg::atmb_rsp_type pending_elems[$];
      int                     mismatches;

      function new();
         bit [63:0]  frac;
         bit [63:0]  x;
         bit [63:0]  x2;
         bit [63:0]  term;
         bit [63:0]  sum;
         bit [63:0]  r;
         bit [127:0] wide;
         bit         minus;
         int         n;
         mismatches = 0;
         for (int k = 0; k < QUARTER; k++) begin
            frac = 64'(k) << (64 - (ANGLE_BITS - 2));
            wide = {64'd0, frac} * {64'd0, QUARTER_TURN_Q62};
            x = wide[127:64];
            x2 = q62_product(x, x);
            term = x;
            sum = x;
            n = 1;
            minus = 1'b1;
            while (term != 64'd0 && n < 60) begin
               term = q62_product(term, x2) / (64'(n + 1) * 64'(n + 2));
               n += 2;
               sum = minus ? sum - term : sum + term;
               minus = !minus;
            end
            r = (sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
            if (r > 64'(UNITY)) r = 64'(UNITY);
            sine_lut[k] = longint'(r);
         end
         sine_lut[QUARTER] = UNITY;
      endfunction

      function bit [63:0] q62_product(bit [63:0] a, bit [63:0] b);
         bit [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         return p[125:62];
      endfunction

      function longint round_product(longint scale, longint trig);
         longint v;
         v = (scale * trig + (UNITY >>> 1)) >>> FRAC_BITS;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v;
      endfunction

      function void note_request(atmb_pkg::atmb_req_type r);
         longint                 sn;
         longint                 cs;
         longint                 rot[9];
         longint                 sc[3];
         longint                 m[16];
         atmb_pkg::atmb_rsp_type want;
         int                     part;
         part = r.turn_angle[ANGLE_BITS-3:0];
         case (r.turn_angle[ANGLE_BITS-1:ANGLE_BITS-2])
            2'd0: begin
               sn = sine_lut[part];
               cs = sine_lut[QUARTER - part];
            end
            2'd1: begin
               sn = sine_lut[QUARTER - part];
               cs = -sine_lut[part];
            end
            2'd2: begin
               sn = -sine_lut[part];
               cs = -sine_lut[QUARTER - part];
            end
            default: begin
               sn = -sine_lut[QUARTER - part];
               cs = sine_lut[part];
            end
         endcase
         foreach (rot[i]) rot[i] = (i % 4 == 0) ? UNITY : 0;
         case (r.turn_axis)
            atmb_pkg::AXIS_X: begin
               rot[4] = cs; rot[5] = sn; rot[7] = -sn; rot[8] = cs;
            end
            atmb_pkg::AXIS_Y: begin
               rot[0] = cs; rot[2] = -sn; rot[6] = sn; rot[8] = cs;
            end
            atmb_pkg::AXIS_Z: begin
               rot[0] = cs; rot[1] = sn; rot[3] = -sn; rot[4] = cs;
            end
            default: begin
            end
         endcase
         sc[0] = r.scale_x;
         sc[1] = r.scale_y;
         sc[2] = r.scale_z;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) m[4*i+j] = round_product(sc[i], rot[3*i+j]);
            m[4*i+3] = 0;
         end
         m[12] = r.offset_x;
         m[13] = r.offset_y;
         m[14] = r.offset_z;
         m[15] = UNITY;
         for (int i = 0; i < 16; i++) begin
            want.element_index = atmb_pkg::INDEX_W'(i);
            want.element_value = m[i][atmb_pkg::ELEM_W-1:0];
            want.last_element  = (atmb_pkg::INDEX_W'(i) == atmb_pkg::LAST_INDEX);
            pending_elems.push_back(want);
         end
      endfunction

      function void check_element(atmb_pkg::atmb_rsp_type got);
         atmb_pkg::atmb_rsp_type want;
         if (pending_elems.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected element: index %0d value %h last %b",
                        got.element_index, got.element_value, got.last_element);
            return;
         end
         want = pending_elems.pop_front();
         if (got.element_index !== want.element_index ||
             got.element_value !== want.element_value ||
             got.last_element !== want.last_element) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"element mismatch: expected index %0d value %h last %b,",
                         " got index %0d value %h last %b"},
                        want.element_index, want.element_value, want.last_element,
                        got.element_index, got.element_value, got.last_element);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   atmb_pkg::atmb_req_type req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   atmb_pkg::atmb_rsp_type rsp_item;

   matrix_scoreboard book = new();
   int idle_cycles = 0;
   int burst_left = 0;

   affine_transform_matrix_build u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) book.note_request(req_item);
         if (rsp_valid === 1'b1 && !rsp_stall) book.check_element(rsp_item);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : rsp_stall_pattern
      int mode;
      int period;
      int phase;
      forever begin
         mode = $urandom_range(0, 3);
         period = $urandom_range(2, 17);
         phase = 0;
         repeat ($urandom_range(20, 150)) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= (phase < period / 2 + 1);
            endcase
            phase = (phase + 1) % period;
         end
      end
   end

   function automatic logic [atmb_pkg::ELEM_W-1:0] random_fixed();
      case ($urandom_range(0, 3))
         0: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         1: return atmb_pkg::ELEM_W'($urandom_range(0, 16 << FRAC_BITS))
                   - (32'd8 << FRAC_BITS);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input atmb_pkg::atmb_req_type r);
      int gap;
      req_item <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin : stimulus
      logic [atmb_pkg::ANGLE_FIELD_W-1:0] edge_angles[7] =
         '{0, 1, 1023, 1024, 2048, 3072, 4095};
      logic [atmb_pkg::ANGLE_FIELD_W-1:0] quad_angles[8] =
         '{0, 1023, 1024, 2047, 2048, 3071, 3072, 4095};
      logic [atmb_pkg::AXIS_W-1:0]        axes[3] =
         '{atmb_pkg::AXIS_X, atmb_pkg::AXIS_Y, atmb_pkg::AXIS_Z};
      logic [atmb_pkg::ELEM_W-1:0]        fill;
      atmb_pkg::atmb_req_type             r;
      int                                 mode;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 7; j++) begin
            mode = (a * 7 + j) % 4;
            fill = (mode == 0) ? 32'h8000_0000 : (mode == 1) ? 32'h7FFF_FFFF :
                   (mode == 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            r.offset_x   = fill;
            r.offset_y   = ~fill;
            r.offset_z   = fill;
            r.scale_x    = fill;
            r.scale_y    = fill;
            r.scale_z    = fill;
            r.turn_angle = edge_angles[j];
            r.turn_axis  = axes[a];
            send_request(r);
         end
      end

      // The most negative scale times a trig value of minus one saturates.
      r.offset_x = 32'h0001_0000;
      r.offset_y = 32'hFFFF_0000;
      r.offset_z = 32'h0000_0001;
      r.scale_x = 32'h8000_0000;
      r.scale_y = 32'h8000_0000;
      r.scale_z = 32'h8000_0000;
      r.turn_axis = atmb_pkg::AXIS_X;
      r.turn_angle = 2048;
      send_request(r);
      r.turn_axis = atmb_pkg::AXIS_Z;
      r.turn_angle = 1024;
      send_request(r);
      r.turn_axis = atmb_pkg::AXIS_Y;
      r.turn_angle = 3072;
      send_request(r);

      repeat (RANDOM_ITEMS) begin
         r.offset_x   = random_fixed();
         r.offset_y   = random_fixed();
         r.offset_z   = random_fixed();
         r.scale_x    = random_fixed();
         r.scale_y    = random_fixed();
         r.scale_z    = random_fixed();
         r.turn_angle = ($urandom_range(0, 4) == 0) ? quad_angles[$urandom_range(0, 7)] :
                        atmb_pkg::ANGLE_FIELD_W'($urandom_range(0, 4095));
         r.turn_axis  = axes[$urandom_range(0, 2)];
         send_request(r);
      end
      req_valid <= 1'b0;

      while (book.pending_elems.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (book.mismatches == 0 && book.pending_elems.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
